// ===== design/tgp_pkg.sv =====
// Shared types and constants for the text glyph placer.
`timescale 1ns / 1ps

package tgp_pkg;

    localparam int TBL_DEPTH = 256;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    typedef enum logic [1:0] {
        CMD_TEXT   = 2'd0,
        CMD_TBL_WR = 2'd1,
        CMD_PAGE   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_GLYPH = 2'd0,
        KIND_FULL  = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        MODE_UTF8   = 2'd0,
        MODE_U16_BE = 2'd1,
        MODE_U16_LE = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        REG_CHARSET   = 3'd0,
        REG_LEFT_MARG = 3'd1,
        REG_LINE_W    = 3'd2,
        REG_LINE_H    = 3'd3,
        REG_ROWS      = 3'd4,
        REG_WIDE_W    = 3'd5
    } t_reg_idx;

    localparam logic [7:0]  CH_LF       = 8'h0a;
    localparam logic [7:0]  CH_CR       = 8'h0d;
    localparam logic [7:0]  CH_FF       = 8'hff;
    localparam logic [7:0]  CH_FE       = 8'hfe;
    localparam logic [7:0]  LEAD3_MASK  = 8'hf0;
    localparam logic [7:0]  LEAD3_VAL   = 8'he0;
    localparam logic [7:0]  LEAD2_MASK  = 8'he0;
    localparam logic [7:0]  LEAD2_VAL   = 8'hc0;
    localparam logic [15:0] U16_LF      = 16'h000a;
    localparam logic [15:0] U16_CR      = 16'h000d;
    localparam logic [15:0] U16_END_BE  = 16'hfffe;
    localparam logic [15:0] U16_END_LE  = 16'hfeff;
    localparam logic [15:0] U16_NARROW  = 16'h0080;
    localparam logic [7:0]  ROWS_MAX    = 8'hff;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] left_margin;
        logic [11:0] line_width;
        logic [7:0]  line_height;
        logic [7:0]  rows_per_page;
        logic [7:0]  wide_width;
    } t_cfg;

    typedef struct packed {
        logic [12:0] x;
        logic [15:0] y;
        logic [7:0]  rows;
    } t_pen;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] code;
        logic [12:0] x;
        logic [15:0] y;
        logic        last;
    } t_res;

    typedef struct packed {
        t_pen pen;
        logic closed;
        t_res res;
    } t_place;

endpackage

// ===== design/text_glyph_placer_top.sv =====
// Text glyph placer: UTF-8 / UTF-16 decode with greedy line wrap.
// Path: input register, decode, then the two-entry result queue to the ports.
// Throughput: one input beat per cycle while the result queue has room; a beat
// that makes two results (held FF flushed plus the next glyph) fills both entries.
// Reset (i_rst_n low, synchronous): config to defaults, page closed, pen,
// decoder state and result queue cleared; the width table is not cleared.
`timescale 1ns / 1ps

module text_glyph_placer_top
    import tgp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // input beat channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_text_byte,
    input  logic [7:0]  i_table_index,
    input  logic [7:0]  i_table_width,

    // result beat channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_code_point,
    output logic [12:0] o_x_pos,
    output logic [15:0] o_y_pos,
    output logic        o_last,

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_cfg r_cfg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode          <= MODE_UTF8;
            r_cfg.left_margin   <= '0;
            r_cfg.line_width    <= '0;
            r_cfg.line_height   <= '0;
            r_cfg.rows_per_page <= 8'd1;
            r_cfg.wide_width    <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_CHARSET:   r_cfg.mode          <= pwdata[1:0];
                REG_LEFT_MARG: r_cfg.left_margin   <= pwdata[11:0];
                REG_LINE_W:    r_cfg.line_width    <= pwdata[11:0];
                REG_LINE_H:    r_cfg.line_height   <= pwdata[7:0];
                REG_ROWS:      r_cfg.rows_per_page <= pwdata[7:0];
                REG_WIDE_W:    r_cfg.wide_width    <= pwdata[7:0];
                default: ;  // addresses past the register list are dropped
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[4:2])
            REG_CHARSET:   prdata = 32'(r_cfg.mode);
            REG_LEFT_MARG: prdata = 32'(r_cfg.left_margin);
            REG_LINE_W:    prdata = 32'(r_cfg.line_width);
            REG_LINE_H:    prdata = 32'(r_cfg.line_height);
            REG_ROWS:      prdata = 32'(r_cfg.rows_per_page);
            REG_WIDE_W:    prdata = 32'(r_cfg.wide_width);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register and width table.
    // The table is written and read on the accepting edge, so the read
    // data lines up with the beat in the input register. Writes land in
    // beat order, so a later byte always sees an earlier table write.
    // ------------------------------------------------------------------
    logic        in_acc;
    logic        go;
    logic        r_in_valid;
    logic [1:0]  r_cmd;
    logic [7:0]  r_byte;
    logic [7:0]  r_tidx;
    logic [7:0]  r_twid;
    logic [7:0]  r_rdw;

    logic [7:0]  r_tbl [TBL_DEPTH];

    assign o_stall = r_in_valid && !go;
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (i_cmd == CMD_TBL_WR) begin
                r_tbl[i_table_index[TBL_AW-1:0]] <= i_table_width;
            end
            r_rdw <= r_tbl[i_text_byte[TBL_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd  <= i_cmd;
            r_byte <= i_text_byte;
            r_tidx <= i_table_index;
            r_twid <= i_table_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Layout and decoder state
    // ------------------------------------------------------------------
    t_pen        r_pen,  n_pen;
    logic        r_open, n_open;
    logic [1:0]  r_bl,   n_bl;      // UTF-8 continuation bytes still due
    logic [15:0] r_acc,  n_acc;     // UTF-8 code being assembled
    logic [7:0]  r_hu,   n_hu;      // first byte of a UTF-16 unit
    logic [7:0]  r_hw,   n_hw;      // table width of that first byte
    logic        r_hp,   n_hp;      // second byte of a unit is next
    logic        r_sw,   n_sw;      // drop an LF right after a new line
    logic        r_pff,  n_pff;     // UTF-8 FF held for the end check
    logic [7:0]  r_ffw;             // shadow of the table entry for FF

    t_res        res_buf [2];
    logic [1:0]  res_cnt;

    function automatic logic [7:0] f_bump(input logic [7:0] rows);
        f_bump = (rows == ROWS_MAX) ? ROWS_MAX : rows + 8'd1;
    endfunction

    function automatic t_res f_res(input logic [1:0] kind, input logic [15:0] code,
                                   input t_pen p);
        t_res r;
        r.kind = kind;
        r.code = code;
        r.x    = p.x;
        r.y    = p.y;
        r.last = 1'b0;
        return r;
    endfunction

    // Place one glyph: wrap when it crosses the right edge, close the page
    // when the wrap runs out of rows.
    function automatic t_place f_place(input t_pen p, input logic [15:0] code,
                                       input logic [7:0] w, input t_cfg c);
        t_place      r;
        logic [13:0] lim;
        logic [13:0] sum;
        r.pen    = p;
        r.closed = 1'b0;
        lim = 14'(c.left_margin) + 14'(c.line_width);
        sum = 14'(p.x) + 14'(w);
        if (sum > lim) begin
            r.pen.rows = f_bump(p.rows);
            if (r.pen.rows >= c.rows_per_page) begin
                r.closed = 1'b1;
            end else begin
                r.pen.x = 13'(c.left_margin);
                r.pen.y = p.y + 16'(c.line_height);
            end
        end
        if (r.closed) begin
            r.res = f_res(KIND_FULL, 16'd0, r.pen);
        end else begin
            r.res   = f_res(KIND_GLYPH, code, r.pen);
            r.pen.x = r.pen.x + 13'(w);
        end
        return r;
    endfunction

    always_comb begin : proc_beat
        t_place      pl;
        logic        done;
        logic        closed;
        logic        big;
        logic [15:0] unit;
        logic [7:0]  uw;

        n_pen   = r_pen;
        n_open  = r_open;
        n_bl    = r_bl;
        n_acc   = r_acc;
        n_hu    = r_hu;
        n_hw    = r_hw;
        n_hp    = r_hp;
        n_sw    = r_sw;
        n_pff   = r_pff;
        res_buf[0] = '0;
        res_buf[1] = '0;
        res_cnt = 2'd0;
        pl      = '0;
        done    = 1'b0;
        closed  = 1'b0;
        big     = (r_cfg.mode == MODE_U16_BE);
        unit    = big ? {r_hu, r_byte} : {r_byte, r_hu};
        uw      = big ? r_rdw : r_hw;

        unique case (r_cmd)
            CMD_TBL_WR: begin
                // keep the held UTF-16 byte's width current
                if (r_tidx == r_hu) begin
                    n_hw = r_twid;
                end
            end
            CMD_PAGE: begin
                n_pen.x    = 13'(r_cfg.left_margin);
                n_pen.y    = '0;
                n_pen.rows = '0;
                n_open     = 1'b1;
                n_bl       = '0;
                n_acc      = '0;
                n_hu       = '0;
                n_hp       = 1'b0;
                n_sw       = 1'b0;
                n_pff      = 1'b0;
            end
            CMD_TEXT: begin
                if (r_open) begin
                    unique case (r_cfg.mode)
                        MODE_UTF8: begin
                            if (r_bl != 2'd0) begin
                                // any byte counts as continuation here
                                n_acc = {r_acc[9:0], r_byte[5:0]};
                                n_bl  = r_bl - 2'd1;
                                if (n_bl == 2'd0) begin
                                    pl = f_place(n_pen, n_acc, r_cfg.wide_width, r_cfg);
                                    n_pen = pl.pen;
                                    closed = pl.closed;
                                    res_buf[res_cnt[0]] = pl.res;
                                    res_cnt = res_cnt + 2'd1;
                                end
                            end else begin
                                if (r_sw) begin
                                    n_sw = 1'b0;
                                    if (r_byte == CH_LF) begin
                                        done = 1'b1;
                                    end
                                end
                                if (!done && r_pff) begin
                                    n_pff = 1'b0;
                                    if (r_byte == CH_FE) begin
                                        closed = 1'b1;
                                        done   = 1'b1;
                                        res_buf[res_cnt[0]] = f_res(KIND_END, 16'd0, n_pen);
                                        res_cnt = res_cnt + 2'd1;
                                    end else begin
                                        // flush the held FF as a narrow glyph
                                        pl = f_place(n_pen, 16'(CH_FF), r_ffw, r_cfg);
                                        n_pen = pl.pen;
                                        res_buf[res_cnt[0]] = pl.res;
                                        res_cnt = res_cnt + 2'd1;
                                        if (pl.closed) begin
                                            closed = 1'b1;
                                            done   = 1'b1;
                                        end
                                    end
                                end
                                if (!done) begin
                                    if (r_byte == CH_LF || r_byte == CH_CR) begin
                                        n_pen.rows = f_bump(n_pen.rows);
                                        n_pen.x    = 13'(r_cfg.left_margin);
                                        n_pen.y    = n_pen.y + 16'(r_cfg.line_height);
                                        n_sw       = 1'b1;
                                        if (n_pen.rows >= r_cfg.rows_per_page) begin
                                            closed = 1'b1;
                                            res_buf[res_cnt[0]] =
                                                f_res(KIND_FULL, 16'd0, n_pen);
                                            res_cnt = res_cnt + 2'd1;
                                        end
                                    end else if (r_byte == CH_FF) begin
                                        n_pff = 1'b1;
                                    end else if ((r_byte & LEAD3_MASK) == LEAD3_VAL) begin
                                        n_acc = {12'd0, r_byte[3:0]};
                                        n_bl  = 2'd2;
                                    end else if ((r_byte & LEAD2_MASK) == LEAD2_VAL) begin
                                        n_acc = {11'd0, r_byte[4:0]};
                                        n_bl  = 2'd1;
                                    end else begin
                                        pl = f_place(n_pen, 16'(r_byte), r_rdw, r_cfg);
                                        n_pen = pl.pen;
                                        closed = pl.closed;
                                        res_buf[res_cnt[0]] = pl.res;
                                        res_cnt = res_cnt + 2'd1;
                                    end
                                end
                            end
                        end
                        MODE_U16_BE, MODE_U16_LE: begin
                            if (!r_hp) begin
                                n_hu = r_byte;
                                n_hw = r_rdw;
                                n_hp = 1'b1;
                            end else begin
                                n_hp = 1'b0;
                                if (r_sw) begin
                                    n_sw = 1'b0;
                                    if (unit == U16_LF) begin
                                        done = 1'b1;
                                    end
                                end
                                if (!done) begin
                                    if (unit == U16_CR || unit == U16_LF) begin
                                        n_pen.rows = f_bump(n_pen.rows);
                                        n_pen.x    = 13'(r_cfg.left_margin);
                                        n_pen.y    = n_pen.y + 16'(r_cfg.line_height);
                                        n_sw       = 1'b1;
                                        if (n_pen.rows >= r_cfg.rows_per_page) begin
                                            closed = 1'b1;
                                            res_buf[res_cnt[0]] =
                                                f_res(KIND_FULL, 16'd0, n_pen);
                                            res_cnt = res_cnt + 2'd1;
                                        end
                                    end else if ((big && unit == U16_END_BE) ||
                                                 (!big && unit == U16_END_LE)) begin
                                        closed = 1'b1;
                                        res_buf[res_cnt[0]] = f_res(KIND_END, 16'd0, n_pen);
                                        res_cnt = res_cnt + 2'd1;
                                    end else begin
                                        pl = f_place(n_pen, unit,
                                                     (unit < U16_NARROW) ? uw
                                                                         : r_cfg.wide_width,
                                                     r_cfg);
                                        n_pen = pl.pen;
                                        closed = pl.closed;
                                        res_buf[res_cnt[0]] = pl.res;
                                        res_cnt = res_cnt + 2'd1;
                                    end
                                end
                            end
                        end
                        default: ;  // unused charset code: drop the byte
                    endcase
                end
            end
            default: ;  // unused command code: drop the beat
        endcase

        // a closed page drops every partial sequence
        if (closed) begin
            n_open = 1'b0;
            n_bl   = '0;
            n_acc  = '0;
            n_hu   = '0;
            n_hp   = 1'b0;
            n_sw   = 1'b0;
            n_pff  = 1'b0;
        end

        if (res_cnt == 2'd2) begin
            res_buf[1].last = 1'b1;
        end else if (res_cnt == 2'd1) begin
            res_buf[0].last = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result queue: two entries, head drives the output ports. A beat
    // advances out of the input register only when its results fit.
    // ------------------------------------------------------------------
    t_res       r_q [2];
    t_res       n_q [2];
    logic [1:0] r_qcnt, n_qcnt;
    logic       pop;
    logic [1:0] cnt_after;

    assign o_valid      = (r_qcnt != 2'd0);
    assign pop          = o_valid && !i_stall;
    assign cnt_after    = r_qcnt - {1'b0, pop};
    assign go           = r_in_valid && (res_cnt <= (2'd2 - cnt_after));

    assign o_kind       = r_q[0].kind;
    assign o_code_point = r_q[0].code;
    assign o_x_pos      = r_q[0].x;
    assign o_y_pos      = r_q[0].y;
    assign o_last       = r_q[0].last;

    always_comb begin
        n_q[0] = r_q[0];
        n_q[1] = r_q[1];
        if (pop) begin
            n_q[0] = r_q[1];
        end
        if (go) begin
            if (res_cnt == 2'd2) begin
                n_q[0] = res_buf[0];
                n_q[1] = res_buf[1];
            end else if (res_cnt == 2'd1) begin
                n_q[cnt_after[0]] = res_buf[0];
            end
        end
        n_qcnt = cnt_after + (go ? res_cnt : 2'd0);
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

    // payload-like state: no reset needed
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_hw <= n_hw;
            if (r_cmd == CMD_TBL_WR && r_tidx[TBL_AW-1:0] == CH_FF[TBL_AW-1:0]) begin
                r_ffw <= r_twid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcnt <= '0;
            r_pen  <= '0;
            r_open <= 1'b0;
            r_bl   <= '0;
            r_acc  <= '0;
            r_hu   <= '0;
            r_hp   <= 1'b0;
            r_sw   <= 1'b0;
            r_pff  <= 1'b0;
        end else begin
            r_qcnt <= n_qcnt;
            if (go) begin
                r_pen  <= n_pen;
                r_open <= n_open;
                r_bl   <= n_bl;
                r_acc  <= n_acc;
                r_hu   <= n_hu;
                r_hp   <= n_hp;
                r_sw   <= n_sw;
                r_pff  <= n_pff;
            end
        end
    end

endmodule
